// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared helpers for concurrent checks, clocked on clk, off during rst
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge outside reset
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error(msg);

// trigger implies consequent on the following edge
`define ASSERT_NEXT(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

// trigger implies consequent on the same edge
`define ASSERT_SAME(label, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) \
    else $error(msg);

`endif

// File: rtl/utf8pl_pkg.sv
// ----------------------------------------------------------------------------
// utf8pl_pkg
// types and constants shared by the utf-8 page layout block
// ----------------------------------------------------------------------------
`default_nettype none

package utf8pl_pkg;

  localparam int COUNT_BITS = 11;

  localparam logic [7:0] RST_LINE_WIDTH_LIMIT  = 8'd208;
  localparam logic [5:0] RST_WIDE_CHAR_WIDTH   = 6'd12;
  localparam logic [5:0] RST_NARROW_CHAR_WIDTH = 6'd6;
  localparam logic [3:0] RST_MAX_LINES         = 4'd7;

  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [3:0] LINES_TOP = 4'd15;
  localparam logic [COUNT_BITS-1:0] PAGE_BYTES_TOP = '1;

  typedef enum logic [1:0] {
    REG_LINE_WIDTH_LIMIT  = 2'd0,
    REG_WIDE_CHAR_WIDTH   = 2'd1,
    REG_NARROW_CHAR_WIDTH = 2'd2,
    REG_MAX_LINES         = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    ACT_GLYPH  = 3'd0,
    ACT_CONT   = 3'd1,
    ACT_BREAK  = 3'd2,
    ACT_CRLF   = 3'd3,
    ACT_REJECT = 3'd4
  } action_t;

  typedef struct packed {
    logic [7:0] line_width_limit;
    logic [5:0] wide_char_width;
    logic [5:0] narrow_char_width;
    logic [3:0] max_lines;
  } cfg_t;

  typedef struct packed {
    logic [7:0]            line_fill;
    logic [3:0]            lines_used;
    logic                  line_open;
    logic [1:0]            cont_bytes_left;
    logic                  cr_seen;
    logic [COUNT_BITS-1:0] page_bytes;
  } layout_state_t;

  typedef struct packed {
    action_t               action;
    logic [7:0]            x_pos;
    logic [3:0]            line_index;
    logic [COUNT_BITS-1:0] bytes_consumed;
    logic                  page_done;
  } layout_result_t;

  // continuation bytes due after a lead byte
  function automatic logic [1:0] cont_count(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b[7] == 1'b0) begin
      n = 2'd0;
    end else if ((b & 8'hE0) == 8'hC0) begin
      n = 2'd1;
    end else if ((b & 8'hF0) == 8'hE0) begin
      n = 2'd2;
    end else if ((b & 8'hF8) == 8'hF0) begin
      n = 2'd3;
    end
    return n;
  endfunction

  function automatic logic [3:0] line_inc(input logic [3:0] used);
    return (used == LINES_TOP) ? used : used + 4'd1;
  endfunction

endpackage

`default_nettype wire

// File: rtl/utf8pl_layout_core.sv
// ----------------------------------------------------------------------------
// utf8pl_layout_core
// next-state and result logic for one text byte of the page layout
// ----------------------------------------------------------------------------
`default_nettype none

module utf8pl_layout_core
  import utf8pl_pkg::*;
(
  input  wire logic [7:0]    text_byte,
  input  wire logic          end_of_text,
  input  wire cfg_t          cfg,
  input  wire layout_state_t state,
  output layout_state_t      state_next,
  output layout_result_t     result
);

  always_comb begin
    layout_state_t s;
    action_t       act;
    logic [7:0]    x;
    logic [3:0]    line;
    logic          count;
    logic [1:0]    ncont;
    logic [5:0]    w;
    logic [8:0]    fill_sum;
    logic          done;

    s     = state;
    act   = ACT_GLYPH;
    x     = 8'd0;
    line  = state.lines_used;
    count = 1'b0;
    ncont = cont_count(text_byte);
    w     = (ncont != 2'd0) ? cfg.wide_char_width : cfg.narrow_char_width;
    fill_sum = 9'd0;

    if (state.cont_bytes_left != 2'd0) begin
      s.cont_bytes_left = state.cont_bytes_left - 2'd1;
      act   = ACT_CONT;
      count = 1'b1;
    end else if (state.cr_seen && text_byte == CHAR_LF) begin
      s.cr_seen = 1'b0;
      act   = ACT_CRLF;
      line  = (state.lines_used != 4'd0) ? state.lines_used - 4'd1 : 4'd0;
      count = 1'b1;
    end else begin
      s.cr_seen = 1'b0;
      if (s.line_open && s.line_fill >= cfg.line_width_limit) begin
        s.line_open  = 1'b0;
        s.line_fill  = 8'd0;
        s.lines_used = line_inc(s.lines_used);
      end
      if (!s.line_open && s.lines_used < cfg.max_lines) begin
        s.line_open = 1'b1;
        s.line_fill = 8'd0;
      end
      if (!s.line_open) begin
        act = ACT_REJECT;
      end else if (text_byte == CHAR_LF || text_byte == CHAR_CR) begin
        act       = ACT_BREAK;
        s.cr_seen = (text_byte == CHAR_CR);
        count     = 1'b1;
      end else begin
        fill_sum = {1'b0, s.line_fill} + {3'b000, w};
        if (fill_sum > {1'b0, cfg.line_width_limit}) begin
          if (s.line_fill == 8'd0 || {2'b00, w} > cfg.line_width_limit) begin
            act = ACT_REJECT;
          end else begin
            s.line_fill  = 8'd0;
            s.lines_used = line_inc(s.lines_used);
            if (s.lines_used < cfg.max_lines) begin
              s.line_open = 1'b1;
            end else begin
              s.line_open = 1'b0;
              act = ACT_REJECT;
            end
          end
        end
        if (act == ACT_GLYPH) begin
          x                 = s.line_fill;
          s.line_fill       = s.line_fill + {2'b00, w};
          s.cont_bytes_left = ncont;
          count             = 1'b1;
        end
      end
      line = s.lines_used;
      if (act == ACT_BREAK) begin
        s.line_open  = 1'b0;
        s.line_fill  = 8'd0;
        s.lines_used = line_inc(s.lines_used);
      end
    end

    if (count && s.page_bytes != PAGE_BYTES_TOP) begin
      s.page_bytes = s.page_bytes + COUNT_BITS'(1);
    end

    done = (act == ACT_REJECT) || end_of_text;

    result.action         = act;
    result.x_pos          = x;
    result.line_index     = line;
    result.bytes_consumed = s.page_bytes;
    result.page_done      = done;

    state_next = done ? '0 : s;
  end

endmodule

`default_nettype wire

// File: rtl/utf8pl_top_body_placeholder.sv
// ----------------------------------------------------------------------------
// utf8pl_cfg_regs
// apb-style register file for the layout settings
// ----------------------------------------------------------------------------
`default_nettype none

module utf8pl_cfg_regs
  import utf8pl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.line_width_limit  <= RST_LINE_WIDTH_LIMIT;
      cfg.wide_char_width   <= RST_WIDE_CHAR_WIDTH;
      cfg.narrow_char_width <= RST_NARROW_CHAR_WIDTH;
      cfg.max_lines         <= RST_MAX_LINES;
    end else if (wr_en) begin
      case (idx)
        REG_LINE_WIDTH_LIMIT:  cfg.line_width_limit  <= pwdata[7:0];
        REG_WIDE_CHAR_WIDTH:   cfg.wide_char_width   <= pwdata[5:0];
        REG_NARROW_CHAR_WIDTH: cfg.narrow_char_width <= pwdata[5:0];
        REG_MAX_LINES:         cfg.max_lines         <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LINE_WIDTH_LIMIT:  prdata = {24'd0, cfg.line_width_limit};
      REG_WIDE_CHAR_WIDTH:   prdata = {26'd0, cfg.wide_char_width};
      REG_NARROW_CHAR_WIDTH: prdata = {26'd0, cfg.narrow_char_width};
      REG_MAX_LINES:         prdata = {28'd0, cfg.max_lines};
      default:               prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/utf8_text_page_layout_top.sv
// ----------------------------------------------------------------------------
// utf8_text_page_layout_top
// greedy utf-8 line wrap of a byte stream onto one page
// ----------------------------------------------------------------------------
// One byte is taken per clock and one result comes out per byte. A byte
// lands in an input register, the layout logic runs between that register
// and the result register, and the page state is updated on the same edge
// that loads the result, so the result is valid once the byte has moved
// from the input register into the result register. A stall on the result
// side holds both registers; the input side stalls only when its register
// is full and cannot move on. Settings are to be written through the
// apb-style port only while no byte is in flight, which the user must ensure.
`default_nettype none

module utf8_text_page_layout_top
  import utf8pl_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [3:0]            paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  input  wire logic                  text_valid,
  output logic                       text_stall,
  input  wire logic [7:0]            text_byte,
  input  wire logic                  end_of_text,
  output logic                       result_valid,
  input  wire logic                  result_stall,
  output logic [2:0]                 action,
  output logic [7:0]                 x_pos,
  output logic [3:0]                 line_index,
  output logic [COUNT_BITS-1:0]      bytes_consumed,
  output logic                       page_done
);

  `include "assert_macros.svh"

  cfg_t           cfg;
  layout_state_t  state;
  layout_state_t  state_next;
  layout_result_t res_next;
  layout_result_t res;

  logic       in_full;
  logic [7:0] in_byte;
  logic       in_eot;
  logic       advance;
  logic       take;

  utf8pl_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  utf8pl_layout_core u_core (
    .text_byte   (in_byte),
    .end_of_text (in_eot),
    .cfg         (cfg),
    .state       (state),
    .state_next  (state_next),
    .result      (res_next)
  );

  assign advance    = in_full && (!result_valid || !result_stall);
  assign text_stall = in_full && !advance;
  assign take       = text_valid && !text_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else begin
      in_full <= take || (in_full && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_byte <= text_byte;
      in_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= '0;
      result_valid <= 1'b0;
    end else begin
      if (advance) begin
        state        <= state_next;
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res <= res_next;
    end
  end

  assign action         = res.action;
  assign x_pos          = res.x_pos;
  assign line_index     = res.line_index;
  assign bytes_consumed = res.bytes_consumed;
  assign page_done      = res.page_done;

  `ASSERT_NEXT(a_page_restart, advance && res_next.page_done, state == '0, "page state not cleared after page end")
  `ASSERT_SAME(a_xpos_glyph_only, result_valid && res.action != ACT_GLYPH, res.x_pos == 8'd0, "nonzero x_pos on non-glyph result")
  `ASSERT_ALWAYS(a_cont_no_cr, !(state.cont_bytes_left != 2'd0 && state.cr_seen), "continuation pending together with cr")

endmodule

`default_nettype wire
